// ----- design/rhsm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and modular arithmetic for the rolling hash matcher.
// No dependencies; every other file but rhsm_ram refers to it by scoped names.
package rhsm_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef logic [29:0] hash_t;
  typedef logic [34:0] wide_t;
  typedef logic [255:0][34:0] qptab_t;

  localparam wide_t       HASH_MOD   = 35'd1000000007;
  localparam logic [63:0] HASH_MOD_W = 64'd1000000007;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  typedef logic [2:0] qcount_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
  } result_t;

  typedef struct packed {
    logic       can_issue;
    logic [1:0] pending;
  } core_stat_t;

  // Largest multiple of the modulus not above the bottom of each 2^27 slice.
  function automatic qptab_t build_qptab();
    qptab_t      t;
    logic [63:0] q;
    for (int i = 0; i < 256; i++) begin
      q = (64'(i) << 27) / HASH_MOD_W;
      t[i] = 35'(q * HASH_MOD_W);
    end
    return t;
  endfunction

  localparam qptab_t QPTAB = build_qptab();

  // Reduce a value below 32 times the modulus.
  function automatic hash_t mod_reduce(input wide_t x);
    wide_t r;
    r = x - QPTAB[x[34:27]];
    if (r >= HASH_MOD) r = r - HASH_MOD;
    return r[29:0];
  endfunction

  function automatic wide_t times31(input hash_t a);
    return (wide_t'(a) << 5) - wide_t'(a);
  endfunction

  function automatic hash_t mod_add(input hash_t a, input hash_t b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 31'(HASH_MOD)) s = s - 31'(HASH_MOD);
    return s[29:0];
  endfunction

  function automatic hash_t mod_sub(input hash_t a, input hash_t b);
    logic [30:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) d = d + 31'(HASH_MOD);
    return d[29:0];
  endfunction

endpackage

// ----- design/rolling_hash_string_matcher_top.sv -----
`timescale 1ns / 1ps
// Top level of the rolling hash matcher: input handshake, result credit and queue.
// Depends on rhsm_pkg, rhsm_core, rhsm_out_queue.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | func[1:0], symbol[4:0]
//   output  | out_valid / out_ready| match_found, match_start[31:0]
//
// No word is taken while the previous one is still in s1; the multiply-by-31 and
// reduce loop on the power registers runs through s1.
// A text word's result passes s1, s2 and s3, is pushed into the output queue from s3
// and raises out_valid once it is written there.
// rst is synchronous; the prefix ring needs no clearing pass after it.
// in_ready drops while s1 holds a word or the four-entry queue plus results in flight are full.
module rolling_hash_string_matcher_top #(
  parameter int MAX_PAT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [4:0]  symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        match_found,
  output logic [31:0] match_start
);

  rhsm_pkg::core_stat_t stat;
  rhsm_pkg::result_t    core_res;
  rhsm_pkg::result_t    q_res;
  rhsm_pkg::qcount_t    q_count;
  logic                 core_res_valid;
  logic                 issue;

  assign in_ready = stat.can_issue
                    && ((q_count + rhsm_pkg::qcount_t'(stat.pending))
                        < rhsm_pkg::qcount_t'(rhsm_pkg::Q_DEPTH));
  assign issue    = in_valid && in_ready;

  rhsm_core #(
    .MAX_PAT (MAX_PAT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .func      (func),
    .symbol    (symbol),
    .stat      (stat),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  rhsm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (core_res_valid),
    .wdata     (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (q_res),
    .count     (q_count)
  );

  assign match_found = q_res.match_found;
  assign match_start = q_res.match_start;

endmodule

// ----- design/rhsm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rhsm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rhsm_out_queue.sv -----
`timescale 1ns / 1ps
// Result queue between the hash pipeline and the output channel.
// Depends on rhsm_pkg.
module rhsm_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rhsm_pkg::result_t  wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output rhsm_pkg::result_t  rdata,
  output rhsm_pkg::qcount_t  count
);

  rhsm_pkg::result_t          entries [rhsm_pkg::Q_DEPTH];
  logic [rhsm_pkg::Q_AW-1:0]  wptr;
  logic [rhsm_pkg::Q_AW-1:0]  rptr;
  logic                       pop;

  assign out_valid = count != '0;
  assign rdata     = entries[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + rhsm_pkg::qcount_t'(push) - rhsm_pkg::qcount_t'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < rhsm_pkg::qcount_t'(rhsm_pkg::Q_DEPTH)) || pop)
    else $error("result queue overflow");

endmodule

// ----- design/rhsm_core.sv -----
`timescale 1ns / 1ps
// Hash pipeline: job state, modular multiply-reduce stages and the prefix ring.
// Depends on rhsm_pkg and rhsm_ram.
module rhsm_core #(
  parameter int MAX_PAT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   issue,
  input  logic [1:0]             func,
  input  logic [4:0]             symbol,
  output rhsm_pkg::core_stat_t   stat,
  output logic                   res_valid,
  output rhsm_pkg::result_t      res
);

  localparam int AW = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int LW = $clog2(MAX_PAT + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAT - 1);
  localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_PAT);

  typedef struct packed {
    logic                  valid;
    logic                  is_clear;
    logic                  do_pat;
    logic                  do_text;
    logic                  res;
    logic                  win_ok;
    logic                  first;
    logic                  fwd;
    logic [31:0]           start;
    logic [AW-1:0]         waddr;
    rhsm_pkg::wide_t       x_term;
    rhsm_pkg::wide_t       x_power;
    rhsm_pkg::wide_t       x_shift;
  } s1_t;

  typedef struct packed {
    logic                  valid;
    logic                  is_clear;
    logic                  do_pat;
    logic                  do_text;
    logic                  res;
    logic                  win_ok;
    logic                  first;
    logic                  fwd;
    logic [31:0]           start;
    logic [AW-1:0]         waddr;
    rhsm_pkg::hash_t       term;
    rhsm_pkg::hash_t       old;
  } s2_t;

  typedef struct packed {
    logic                  valid;
    logic                  do_text;
    logic                  res;
    logic                  win_ok;
    logic [31:0]           start;
    logic [AW-1:0]         waddr;
    rhsm_pkg::hash_t       old;
  } s3_t;

  logic [31:0]       text_count;
  logic [LW-1:0]     pattern_length;
  rhsm_pkg::hash_t   pattern_power;
  rhsm_pkg::hash_t   text_power;
  rhsm_pkg::hash_t   shifted_hash;
  rhsm_pkg::hash_t   text_prefix_hash;
  rhsm_pkg::hash_t   pattern_hash;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;

  s1_t s1, s1_next;
  s2_t s2;
  s3_t s3;

  logic [5:0]        code;
  logic [31:0]       end_cnt;
  logic [31:0]       len32;
  rhsm_pkg::hash_t   power_sel;
  logic [35:0]       prod;
  logic [AW-1:0]     rd_ptr_next;
  rhsm_pkg::hash_t   ram_rdata;
  rhsm_pkg::hash_t   window;
  logic              match;

  // Issue stage: decode, window bookkeeping, multiplies.
  always_comb begin
    code      = {1'b0, symbol} + 6'd1;
    end_cnt   = text_count + 32'd1;
    len32     = 32'(pattern_length);
    power_sel = (func == rhsm_pkg::FUNC_TEXT) ? text_power : pattern_power;
    prod      = 36'(code) * 36'(power_sel);

    s1_next          = '0;
    s1_next.valid    = issue;
    s1_next.is_clear = issue && (func == rhsm_pkg::FUNC_CLEAR);
    s1_next.do_pat   = issue && (func == rhsm_pkg::FUNC_PATTERN) && (text_count == '0)
                       && (pattern_length < MAX_LEN);
    s1_next.res      = issue && (func == rhsm_pkg::FUNC_TEXT);
    s1_next.do_text  = s1_next.res && (text_count != '1);
    s1_next.win_ok   = s1_next.do_text && (pattern_length != '0) && (end_cnt >= len32);
    s1_next.start    = end_cnt - len32;
    s1_next.first    = s1_next.start == '0;
    s1_next.fwd      = pattern_length == LW'(1);
    s1_next.waddr    = (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + AW'(1);
    s1_next.x_term   = prod[34:0];
    s1_next.x_power  = rhsm_pkg::times31(power_sel);
    s1_next.x_shift  = rhsm_pkg::times31(shifted_hash);

    rd_ptr_next = (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else begin
      s1 <= s1_next;

      s2.valid    <= s1.valid;
      s2.is_clear <= s1.is_clear;
      s2.do_pat   <= s1.do_pat;
      s2.do_text  <= s1.do_text;
      s2.res      <= s1.res;
      s2.win_ok   <= s1.win_ok;
      s2.first    <= s1.first;
      s2.fwd      <= s1.fwd;
      s2.start    <= s1.start;
      s2.waddr    <= s1.waddr;
      s2.term     <= rhsm_pkg::mod_reduce(s1.x_term);
      s2.old      <= s1.first ? '0 : ram_rdata;

      s3.valid    <= s2.valid;
      s3.do_text  <= s2.do_text;
      s3.res      <= s2.res;
      s3.win_ok   <= s2.win_ok;
      s3.start    <= s2.start;
      s3.waddr    <= s2.waddr;
      // forward the live prefix when the window start is the previous end
      s3.old      <= (s2.fwd && !s2.first) ? text_prefix_hash : s2.old;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count       <= '0;
      pattern_length   <= '0;
      pattern_power    <= 30'd1;
      text_power       <= 30'd1;
      shifted_hash     <= '0;
      text_prefix_hash <= '0;
      pattern_hash     <= '0;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
    end else begin
      priority if (s1_next.is_clear) begin
        text_count     <= '0;
        pattern_length <= '0;
        pattern_power  <= 30'd1;
        text_power     <= 30'd1;
        wr_ptr         <= '0;
        rd_ptr         <= '0;
      end else begin
        if (s1_next.do_pat) pattern_length <= pattern_length + LW'(1);
        if (s1_next.do_text) begin
          text_count <= end_cnt;
          wr_ptr     <= s1_next.waddr;
        end
        if (s1_next.win_ok) rd_ptr <= rd_ptr_next;
        if (s1.do_pat) pattern_power <= rhsm_pkg::mod_reduce(s1.x_power);
        if (s1.do_text) text_power <= rhsm_pkg::mod_reduce(s1.x_power);
        if (s1.win_ok) begin
          shifted_hash <= s1.first ? pattern_hash : rhsm_pkg::mod_reduce(s1.x_shift);
        end
      end

      priority if (s2.is_clear) begin
        text_prefix_hash <= '0;
        pattern_hash     <= '0;
        shifted_hash     <= '0;
      end else begin
        if (s2.do_text) text_prefix_hash <= rhsm_pkg::mod_add(text_prefix_hash, s2.term);
        if (s2.do_pat) pattern_hash <= rhsm_pkg::mod_add(pattern_hash, s2.term);
      end
    end
  end

  rhsm_ram #(
    .WIDTH (30),
    .DEPTH (MAX_PAT)
  ) u_ring (
    .clk   (clk),
    .we    (s3.valid && s3.do_text),
    .waddr (s3.waddr),
    .wdata (text_prefix_hash),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    window          = rhsm_pkg::mod_sub(text_prefix_hash, s3.old);
    match           = s3.win_ok && (window == shifted_hash);
    res_valid       = s3.valid && s3.res;
    res.match_found = match;
    res.match_start = match ? s3.start : '0;
  end

  assign stat.can_issue = !s1.valid;
  assign stat.pending   = 2'(s1.res) + 2'(s2.res) + 2'(s3.res);

  a_issue_spacing: assert property (@(posedge clk) disable iff (rst)
    issue |=> !issue)
    else $error("items issued on consecutive cycles");

  a_text_result: assert property (@(posedge clk) disable iff (rst)
    (issue && func == rhsm_pkg::FUNC_TEXT) |-> ##3 res_valid)
    else $error("text word lost its result");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (issue && func == rhsm_pkg::FUNC_CLEAR) |=> (text_count == '0) && (pattern_length == '0)
      && (rd_ptr == '0) && (wr_ptr == '0))
    else $error("clear left job state behind");

endmodule
